// ----- src/bms_pkg.sv -----
`timescale 1ns / 1ps
// bms_pkg: shared types, constants and fixed-point helpers for the brent minimum search
// depends on nothing; imported by bms_div and brent_minimum_search

package bms_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ITER_BITS_DEF = 10;
  localparam int WW = 70;            // working width of the wide signed datapath
  localparam int DIV_STEPS = 32;     // quotient bits produced by the divider
  localparam longint GOLD_Q30 = 64'sd410132882;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic CFG_REL_TOL    = 1'b0;
  localparam logic CFG_ITER_LIMIT = 1'b1;

  localparam logic [15:0] REL_TOL_RST = 16'd66;
  localparam logic [9:0]  ITER_LIMIT_RST = 10'd100;

  typedef struct packed {
    logic start;
    logic negate;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic signed [WW-1:0] SAT_HI = {{(WW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [WW-1:0] SAT_LO = {{(WW-31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] v);
    if (v > SAT_HI) return 32'sh7FFFFFFF;
    if (v < SAT_LO) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [WW-1:0] ext32(input logic signed [31:0] v);
    return {{(WW-32){v[31]}}, v};
  endfunction

  function automatic logic signed [WW-1:0] abs_w(input logic signed [WW-1:0] v);
    return v[WW-1] ? -v : v;
  endfunction

  // golden section fraction (3 - sqrt 5)/2 rounded to frac fraction bits
  function automatic longint gold_q(input int frac);
    int s;
    s = 30 - frac;
    if (s <= 0) return GOLD_Q30;
    return (GOLD_Q30 + (longint'(1) << (s - 1))) >>> s;
  endfunction

endpackage

// ----- src/brent_minimum_search.sv -----
`timescale 1ns / 1ps
// brent_minimum_search: brent one-dimensional minimizer, objective evaluated outside
// depends on bms_pkg and bms_div
//
// channel  dir  handshake          payload
// in_      in   tvalid/tready      tuser: command; tdata: lower, upper, func value
// out_     out  tvalid/tready      tuser: done; tdata: probe, best value, iterations
// cfg_     in   valid/ready        index, data (rel_tolerance, iteration_limit)
//
// a start passes S_INIT and S_INIT2 before S_EMIT, an idle or done report goes
// straight to S_EMIT, and a report that ends the search leaves at S_ADV or S_TOL
// a step with a golden fallback ends in S_GOLD, S_GOLD2 and S_FIN, a parabolic step
// in S_P1 to S_P9, S_DIV and S_FIN: the shared 34x34 multiplier runs eight products
// in sequence and the divider adds one quotient bit per cycle, then flags completion
// in_tready is high only while the sequencer is idle; a result waits in the output
// register and a finished item stalls only if that register is still full
// reset is synchronous, active low

module brent_minimum_search import bms_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ITER_BITS = ITER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // lower_bound, upper_bound, func_value
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // probe_point, best_value, iterations_used, zero fill
  output logic        out_tuser,  // done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = (ITER_BITS > 10) ? ITER_BITS : 10;
  localparam logic signed [33:0] GOLD = 34'(gold_q(FRAC_BITS));

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001, S_INIT = 20'h00002, S_INIT2 = 20'h00004, S_UPD = 20'h00008,
    S_ADV   = 20'h00010, S_TOL  = 20'h00020, S_P1    = 20'h00040, S_P2  = 20'h00080,
    S_P3    = 20'h00100, S_P4   = 20'h00200, S_P5    = 20'h00400, S_P6  = 20'h00800,
    S_P7    = 20'h01000, S_P8   = 20'h02000, S_P9    = 20'h04000, S_DIV = 20'h08000,
    S_GOLD  = 20'h10000, S_GOLD2 = 20'h20000, S_FIN  = 20'h40000, S_EMIT = 20'h80000
  } seq_state_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001, PH_FIRST = 4'b0010, PH_STEP = 4'b0100, PH_DONE = 4'b1000
  } phase_t;

  seq_state_t state_r, state_nxt;
  phase_t     phase_r;

  logic signed [31:0] a_r, b_r, x_r, w_r, v_r, fx_r, fw_r, fv_r, d_r, e_r, pend_r;
  logic signed [31:0] fin_r, tol1_r, r_r, q_r, p_r, t1_r;
  logic [ITER_BITS-1:0] cnt_r;
  logic [15:0] rel_r;
  logic [9:0]  lim_r;
  logic        ok_r;
  logic signed [67:0] prod_r;
  logic        out_valid_r, out_done_r;
  logic signed [31:0] out_probe_r, out_best_r;
  logic [9:0]  out_iter_r;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  logic signed [31:0] in_lo, in_hi, in_fv;
  logic signed [WW-1:0] x_w, a_w, b_w, sum_w, twox_w, prod_w, mq_w;
  logic signed [31:0] mq, dxw, dxv, dfv3, dfw, dax, dbx, e_gold;
  logic signed [WW-1:0] tol_w, tol1_w, tol2_w, conv_lhs, conv_rhs;
  logic signed [31:0] p_s, qq_s, p_fix, q_abs;
  logic signed [WW-1:0] pone_w, plim_w, u_div, step_w;
  logic        conv, para_try, ok1, ok2, ok3, near_end, lim_hit, cnt_full, out_free;
  logic signed [31:0] init_pt;
  logic [63:0] div_mag;
  div_ctrl_t   div_ctrl;
  div_stat_t   div_st;
  logic signed [31:0] div_q;

  assign in_lo = in_tdata[31:0];
  assign in_hi = in_tdata[63:32];
  assign in_fv = in_tdata[95:64];

  assign x_w    = ext32(x_r);
  assign a_w    = ext32(a_r);
  assign b_w    = ext32(b_r);
  assign sum_w  = a_w + b_w;
  assign twox_w = x_w <<< 1;
  assign prod_w = {{(WW-68){prod_r[67]}}, prod_r};
  assign mq_w   = prod_w >>> FRAC_BITS;
  assign mq     = sat32(mq_w);

  assign dxw  = sat32(x_w - ext32(w_r));
  assign dxv  = sat32(x_w - ext32(v_r));
  assign dfv3 = sat32(ext32(fx_r) - ext32(fv_r));
  assign dfw  = sat32(ext32(fx_r) - ext32(fw_r));
  assign dax  = sat32(a_w - x_w);
  assign dbx  = sat32(b_w - x_w);
  assign e_gold = (twox_w < sum_w) ? dbx : dax;

  // tolerance = rel_tolerance (always sixteen fraction bits) * |x|, plus one lsb
  assign tol_w    = (prod_w >>> 16) + ext32(32'sd1);
  assign conv_lhs = abs_w(twox_w - sum_w);
  assign conv_rhs = (tol_w <<< 2) - (b_w - a_w);
  assign conv     = conv_lhs <= conv_rhs;
  assign para_try = abs_w(ext32(e_r)) > tol_w;
  assign tol1_w   = ext32(tol1_r);
  assign tol2_w   = tol1_w <<< 1;

  assign p_s   = sat32(ext32(t1_r) - ext32(mq));
  assign qq_s  = sat32((ext32(q_r) - ext32(r_r)) <<< 1);
  assign p_fix = (qq_s > 32'sd0) ? sat32(-ext32(p_s)) : p_s;
  assign q_abs = sat32(abs_w(ext32(qq_s)));

  assign pone_w = ext32(p_r) <<< FRAC_BITS;
  assign plim_w = abs_w(ext32(p_r)) <<< (FRAC_BITS + 1);
  assign ok1 = (q_r != 32'sd0) && (plim_w < abs_w(prod_w));
  assign ok2 = pone_w > prod_w;
  assign ok3 = pone_w < prod_w;

  assign div_mag = 64'(abs_w(pone_w));
  assign div_ctrl.start  = (state_r == S_P9) && ok_r && ok3;
  assign div_ctrl.negate = p_r[31];

  // parabolic step landing too close to a bracket end
  assign u_div    = x_w + ext32(div_q);
  assign near_end = ((u_div - a_w) < tol2_w) || ((b_w - u_div) < tol2_w);

  assign step_w = (abs_w(ext32(d_r)) >= tol1_w) ? ext32(d_r)
                : (d_r[31] ? -tol1_w : tol1_w);

  assign init_pt  = 32'(a_w + (prod_w >>> FRAC_BITS));
  assign cnt_full = &cnt_r;
  assign lim_hit  = (CW'(cnt_r) >= CW'(lim_r)) || cnt_full;
  assign out_free = !out_valid_r || out_tready;

  bms_div u_div_unit (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (div_ctrl),
    .dividend_mag (div_mag),
    .divisor      (q_r),
    .quotient     (div_q),
    .stat         (div_st)
  );

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_INIT: begin
        mul_a = {{2{b_r[31]}}, b_r} - {{2{a_r[31]}}, a_r};
        mul_b = GOLD;
      end
      S_ADV: begin
        mul_a = {18'b0, rel_r};
        mul_b = x_r[31] ? -{{2{x_r[31]}}, x_r} : {{2{x_r[31]}}, x_r};
      end
      S_TOL: begin
        mul_a = {{2{dxw[31]}}, dxw};
        mul_b = {{2{dfv3[31]}}, dfv3};
      end
      S_P1: begin
        mul_a = {{2{dxv[31]}}, dxv};
        mul_b = {{2{dfw[31]}}, dfw};
      end
      S_P3: begin
        mul_a = {{2{dxv[31]}}, dxv};
        mul_b = {{2{q_r[31]}}, q_r};
      end
      S_P4: begin
        mul_a = {{2{dxw[31]}}, dxw};
        mul_b = {{2{r_r[31]}}, r_r};
      end
      S_P6: begin
        mul_a = {{2{q_r[31]}}, q_r};
        mul_b = {{2{e_r[31]}}, e_r};
      end
      S_P7: begin
        mul_a = {{2{q_r[31]}}, q_r};
        mul_b = {{2{dax[31]}}, dax};
      end
      S_P8: begin
        mul_a = {{2{q_r[31]}}, q_r};
        mul_b = {{2{dbx[31]}}, dbx};
      end
      S_GOLD: begin
        mul_a = GOLD;
        mul_b = {{2{e_gold[31]}}, e_gold};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CMD_START) state_nxt = S_INIT;
          else if (phase_r == PH_FIRST) state_nxt = S_ADV;
          else if (phase_r == PH_STEP) state_nxt = S_UPD;
          else state_nxt = S_EMIT;
        end
      end
      S_INIT:  state_nxt = S_INIT2;
      S_INIT2: state_nxt = S_EMIT;
      S_UPD:   state_nxt = S_ADV;
      S_ADV:   state_nxt = lim_hit ? S_EMIT : S_TOL;
      S_TOL:   state_nxt = conv ? S_EMIT : (para_try ? S_P1 : S_GOLD);
      S_P1:    state_nxt = S_P2;
      S_P2:    state_nxt = S_P3;
      S_P3:    state_nxt = S_P4;
      S_P4:    state_nxt = S_P5;
      S_P5:    state_nxt = S_P6;
      S_P6:    state_nxt = S_P7;
      S_P7:    state_nxt = S_P8;
      S_P8:    state_nxt = S_P9;
      S_P9:    state_nxt = (ok_r && ok3) ? S_DIV : S_GOLD;
      S_DIV:   state_nxt = div_st.done ? S_FIN : S_DIV;
      S_GOLD:  state_nxt = S_GOLD2;
      S_GOLD2: state_nxt = S_FIN;
      S_FIN:   state_nxt = S_EMIT;
      S_EMIT:  state_nxt = out_free ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      rel_r       <= REL_TOL_RST;
      lim_r       <= ITER_LIMIT_RST;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
      a_r  <= '0; b_r  <= '0; x_r  <= '0; w_r <= '0; v_r <= '0;
      fx_r <= '0; fw_r <= '0; fv_r <= '0; d_r <= '0; e_r <= '0; pend_r <= '0;
    end else begin
      state_r <= state_nxt;
      prod_r  <= mul_p;

      if (cfg_valid) begin
        if (cfg_index == CFG_REL_TOL) rel_r <= cfg_data;
        else lim_r <= cfg_data[9:0];
      end

      // the emit step reloads the output register itself
      if (out_valid_r && out_tready && state_r != S_EMIT) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            fin_r <= in_fv;
            if (in_tuser == CMD_START) begin
              a_r <= (in_lo > in_hi) ? in_hi : in_lo;
              b_r <= (in_lo > in_hi) ? in_lo : in_hi;
            end else if (phase_r == PH_FIRST) begin
              fx_r <= in_fv;
              fw_r <= in_fv;
              fv_r <= in_fv;
            end
          end
        end
        S_INIT2: begin
          x_r <= init_pt; w_r <= init_pt; v_r <= init_pt; pend_r <= init_pt;
          fx_r <= '0; fw_r <= '0; fv_r <= '0; d_r <= '0; e_r <= '0;
          cnt_r   <= '0;
          phase_r <= PH_FIRST;
        end
        S_UPD: begin
          if (fin_r <= fx_r) begin
            if (pend_r < x_r) b_r <= x_r;
            else a_r <= x_r;
            v_r <= w_r; fv_r <= fw_r;
            w_r <= x_r; fw_r <= fx_r;
            x_r <= pend_r; fx_r <= fin_r;
          end else begin
            if (pend_r < x_r) a_r <= pend_r;
            else b_r <= pend_r;
            if (fin_r <= fw_r || w_r == x_r) begin
              v_r <= w_r; fv_r <= fw_r;
              w_r <= pend_r; fw_r <= fin_r;
            end else if (fin_r <= fv_r || v_r == x_r || v_r == w_r) begin
              v_r <= pend_r; fv_r <= fin_r;
            end
          end
          if (!cnt_full) cnt_r <= cnt_r + 1'b1;
        end
        S_ADV: begin
          if (lim_hit) phase_r <= PH_DONE;
        end
        S_TOL: begin
          tol1_r <= tol_w[31:0];
          if (conv) phase_r <= PH_DONE;
        end
        S_P1: r_r <= mq;
        S_P2: q_r <= mq;
        S_P4: t1_r <= mq;
        S_P5: begin
          p_r <= p_fix;
          q_r <= q_abs;
        end
        S_P7: ok_r <= ok1;
        S_P8: ok_r <= ok_r && ok2;
        S_P9: begin
          if (ok_r && ok3) e_r <= d_r;
        end
        S_DIV: begin
          if (div_st.done) begin
            if (near_end) d_r <= (sum_w - twox_w >= 0) ? tol1_r : -tol1_r;
            else d_r <= div_q;
          end
        end
        S_GOLD: e_r <= e_gold;
        S_GOLD2: d_r <= mq;
        S_FIN: begin
          pend_r  <= sat32(x_w + step_w);
          phase_r <= PH_STEP;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_done_r  <= (phase_r == PH_DONE);
            out_iter_r  <= 10'(cnt_r);
            if (phase_r == PH_DONE || phase_r == PH_IDLE) begin
              out_probe_r <= x_r;
              out_best_r  <= fx_r;
            end else begin
              out_probe_r <= pend_r;
              out_best_r  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_iter_r, out_best_r, out_probe_r};
  assign out_tuser  = out_done_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide step");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_free |=> out_tvalid)
    else $error("result not loaded into output register");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctrl.start |-> !div_st.busy)
    else $error("divider restarted while busy");
`endif

endmodule

// ----- src/bms_div.sv -----
`timescale 1ns / 1ps
// bms_div: radix-2 restoring divider, one quotient bit per cycle
// depends on bms_pkg; quotient is known to fit below 2^31

module bms_div import bms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  div_ctrl_t          ctrl,
  input  logic [63:0]        dividend_mag,
  input  logic [31:0]        divisor,
  output logic signed [31:0] quotient,
  output div_stat_t          stat
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [31:0]      rem_r;
  logic [31:0]      dq_r;
  logic [31:0]      div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [32:0]      shifted;
  logic             fits;

  assign shifted = {rem_r, dq_r[31]};
  assign fits    = shifted >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        // upper half is below the divisor, so 32 steps cover the quotient
        rem_r  <= dividend_mag[63:32];
        dq_r   <= dividend_mag[31:0];
        div_r  <= divisor;
        neg_r  <= ctrl.negate;
        cnt_r  <= CNT_W'(DIV_STEPS - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? 32'(shifted - {1'b0, div_r}) : shifted[31:0];
        dq_r  <= {dq_r[30:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg_r ? -$signed(dq_r) : $signed(dq_r);
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
